>>> sv/mix_accumulator_to_pcm_output_macros.svh
// ----------------------------------------------------------------------------
// mix_accumulator_to_pcm_output_macros
// Assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef MIX_ACCUMULATOR_TO_PCM_OUTPUT_MACROS_SVH
`define MIX_ACCUMULATOR_TO_PCM_OUTPUT_MACROS_SVH

// Checked only while out of reset.
`define MACP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("macp assertion failed");

// Checked at every edge, reset included.
`define MACP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("macp assertion failed");

`endif

>>> sv/macp_pkg.sv
// ----------------------------------------------------------------------------
// macp_pkg
// Types, constants and helper functions of the PCM output converter.
// ----------------------------------------------------------------------------
package macp_pkg;

  localparam int MAX_OUT_CHANNELS = 8;
  localparam int MAX_RING_SLOTS   = 1048576;

  localparam int TIME_W   = 31;
  localparam int ACC_W    = 32;
  localparam int WORD_W   = 32;
  localparam int FMT_W    = 2;
  localparam int CHN_W    = 4;
  localparam int RING_W   = 21;
  localparam int SLOT_W   = 20;
  localparam int DVD_W    = TIME_W + CHN_W;
  localparam int CH_IDX_W = $clog2(MAX_OUT_CHANNELS);

  // sample formats
  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_F32 = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_FMT  = 2'd0;
  localparam logic [1:0] REG_CHN  = 2'd1;
  localparam logic [1:0] REG_RING = 2'd2;

  localparam logic [FMT_W-1:0]  FMT_RESET  = FMT_S16;
  localparam logic [CHN_W-1:0]  CHN_RESET  = 4'd2;
  localparam logic [RING_W-1:0] RING_RESET = 21'd65536;

  typedef struct packed {
    logic [FMT_W-1:0]  fmt;
    logic [CHN_W-1:0]  chans;  // clamped to 1..MAX_OUT_CHANNELS
    logic [RING_W-1:0] ring;   // clamped to 1..MAX_RING_SLOTS
  } cfg_t;

  // one restoring remainder step
  function automatic logic [SLOT_W-1:0] div_step(input logic [SLOT_W-1:0] rem,
                                                 input logic              dbit,
                                                 input logic [RING_W-1:0] divisor);
    logic [RING_W-1:0] t;
    logic [RING_W-1:0] d;
    t = {rem, dbit};
    d = t - divisor;
    if (t >= divisor) begin
      return d[SLOT_W-1:0];
    end
    return t[SLOT_W-1:0];
  endfunction

  // encoding of a zero sample for the silent channels
  function automatic logic [WORD_W-1:0] zero_word(input logic [FMT_W-1:0] fmt);
    if (fmt == FMT_U8) begin
      return 32'h0000_0080;
    end
    return '0;
  endfunction

endpackage

>>> sv/mix_accumulator_to_pcm_output.sv
// ----------------------------------------------------------------------------
// mix_accumulator_to_pcm_output
// Converts mixed stereo frames to interleaved PCM ring writes.
// ----------------------------------------------------------------------------
// One frame enters per cycle while the output keeps up; the output issues one
// ring write per cycle while out_ready_i is high, one per output channel of a
// frame, and that write port sets the sustained rate. Between acceptance and
// the first write a frame passes the time*channels product register, the
// bit-per-stage slot remainder pipeline, the sample-lane registers and the
// sequencer's frame register. The pipeline stalls as a whole when the output
// holds a frame it cannot yet release.
module mix_accumulator_to_pcm_output (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [macp_pkg::TIME_W-1:0] paint_time_i,
  input  logic signed [macp_pkg::ACC_W-1:0] left_acc_i,
  input  logic signed [macp_pkg::ACC_W-1:0] right_acc_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [macp_pkg::SLOT_W-1:0] slot_index_o,
  output logic [macp_pkg::WORD_W-1:0] sample_word_o,
  output logic                        last_o
);

  logic [macp_pkg::FMT_W-1:0]  fmt_q;
  logic [macp_pkg::CHN_W-1:0]  chn_q;
  logic [macp_pkg::RING_W-1:0] ring_q;
  macp_pkg::cfg_t              cfg;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= macp_pkg::FMT_RESET;
      chn_q  <= macp_pkg::CHN_RESET;
      ring_q <= macp_pkg::RING_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        macp_pkg::REG_FMT:  fmt_q  <= pwdata[macp_pkg::FMT_W-1:0];
        macp_pkg::REG_CHN:  chn_q  <= pwdata[macp_pkg::CHN_W-1:0];
        macp_pkg::REG_RING: ring_q <= pwdata[macp_pkg::RING_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      macp_pkg::REG_FMT:  prdata = {30'd0, fmt_q};
      macp_pkg::REG_CHN:  prdata = {28'd0, chn_q};
      macp_pkg::REG_RING: prdata = {11'd0, ring_q};
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    cfg.fmt = fmt_q;
    if (chn_q == '0) begin
      cfg.chans = macp_pkg::CHN_W'(1);
    end else if (chn_q > macp_pkg::CHN_W'(macp_pkg::MAX_OUT_CHANNELS)) begin
      cfg.chans = macp_pkg::CHN_W'(macp_pkg::MAX_OUT_CHANNELS);
    end else begin
      cfg.chans = chn_q;
    end
    if (ring_q == '0) begin
      cfg.ring = macp_pkg::RING_W'(1);
    end else if (ring_q > macp_pkg::RING_W'(macp_pkg::MAX_RING_SLOTS)) begin
      cfg.ring = macp_pkg::RING_W'(macp_pkg::MAX_RING_SLOTS);
    end else begin
      cfg.ring = ring_q;
    end
  end

  // global advance: the last lane stage is empty or moves into the sequencer
  logic en;
  logic seq_load;
  logic va_q, vb_q;

  assign en         = !vb_q || seq_load;
  assign in_ready_o = en;

  logic                         s0v_q;
  logic [macp_pkg::DVD_W-1:0]   s0_dvd_q;
  logic [2*macp_pkg::ACC_W-1:0] s0_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0v_q <= 1'b0;
    end else if (en) begin
      s0v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_dvd_q <= macp_pkg::DVD_W'(paint_time_i) * macp_pkg::DVD_W'(cfg.chans);
      s0_tag_q <= {left_acc_i, right_acc_i};
    end
  end

  logic                         dv_valid;
  logic [macp_pkg::SLOT_W-1:0]  dv_rem;
  logic [2*macp_pkg::ACC_W-1:0] dv_tag;

  macp_slot_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s0v_q),
    .dividend_i (s0_dvd_q),
    .divisor_i  (cfg.ring),
    .tag_i      (s0_tag_q),
    .valid_o    (dv_valid),
    .rem_o      (dv_rem),
    .tag_o      (dv_tag)
  );

  logic [macp_pkg::SLOT_W-1:0] base_a_q, base_b_q;
  logic [macp_pkg::WORD_W-1:0] word_l, word_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= dv_valid;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      base_a_q <= dv_rem;
      base_b_q <= base_a_q;
    end
  end

  macp_lane u_lane_l (
    .clk_i  (clk_i),
    .en_i   (en),
    .fmt_i  (cfg.fmt),
    .acc_i  (dv_tag[2*macp_pkg::ACC_W-1:macp_pkg::ACC_W]),
    .word_o (word_l)
  );

  macp_lane u_lane_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .fmt_i  (cfg.fmt),
    .acc_i  (dv_tag[macp_pkg::ACC_W-1:0]),
    .word_o (word_r)
  );

  macp_out_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .valid_i       (vb_q),
    .load_o        (seq_load),
    .base_i        (base_b_q),
    .word0_i       (word_l),
    .word1_i       (word_r),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .slot_index_o  (slot_index_o),
    .sample_word_o (sample_word_o),
    .last_o        (last_o)
  );

endmodule

>>> sv/macp_slot_div.sv
// ----------------------------------------------------------------------------
// macp_slot_div
// Pipelined restoring remainder: dividend mod divisor, one bit per stage.
// Carries a tag alongside each item.
// ----------------------------------------------------------------------------
module macp_slot_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [macp_pkg::DVD_W-1:0]  dividend_i,
  input  logic [macp_pkg::RING_W-1:0] divisor_i,
  input  logic [2*macp_pkg::ACC_W-1:0] tag_i,
  output logic                        valid_o,
  output logic [macp_pkg::SLOT_W-1:0] rem_o,
  output logic [2*macp_pkg::ACC_W-1:0] tag_o
);

  localparam int NST = macp_pkg::DVD_W;

  logic                          vld_q [NST];
  logic [macp_pkg::SLOT_W-1:0]   rem_q [NST];
  logic [macp_pkg::DVD_W-1:0]    dvd_q [NST];
  logic [2*macp_pkg::ACC_W-1:0]  tag_q [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic                          vld_d;
    logic [macp_pkg::SLOT_W-1:0]   rem_in;
    logic [macp_pkg::DVD_W-1:0]    dvd_d;
    logic [2*macp_pkg::ACC_W-1:0]  tag_d;

    if (k == 0) begin : g_first
      assign vld_d  = valid_i;
      assign rem_in = '0;
      assign dvd_d  = dividend_i;
      assign tag_d  = tag_i;
    end else begin : g_rest
      assign vld_d  = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dvd_d  = dvd_q[k-1];
      assign tag_d  = tag_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= macp_pkg::div_step(rem_in, dvd_d[NST-1-k], divisor_i);
        dvd_q[k] <= dvd_d;
        tag_q[k] <= tag_d;
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign rem_o   = rem_q[NST-1];
  assign tag_o   = tag_q[NST-1];

endmodule

>>> sv/macp_lane.sv
// ----------------------------------------------------------------------------
// macp_lane
// One sample lane: 24.8 accumulator to saturated 16-bit, then format encode.
// Two register stages.
// ----------------------------------------------------------------------------
module macp_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [macp_pkg::FMT_W-1:0]  fmt_i,
  input  logic [macp_pkg::ACC_W-1:0]  acc_i,
  output logic [macp_pkg::WORD_W-1:0] word_o
);

  logic signed [23:0] s24;
  logic signed [23:0] lo;
  logic        [15:0] v_d, v_q;
  logic        [15:0] neg;
  logic        [14:0] x_d, x_q;
  logic        [3:0]  lz_d, lz_q;
  logic [macp_pkg::WORD_W-1:0] word_d, word_q;
  logic [59:0] wide;
  logic [59:0] sh;
  logic [7:0]  expo;
  logic [30:0] mag;

  // stage A: floor shift, saturate, magnitude and leading zeros
  always_comb begin
    s24 = $signed(acc_i[31:8]);
    lo  = (fmt_i == macp_pkg::FMT_F32) ? -24'sd32767 : -24'sd32768;
    if (s24 > 24'sd32767) begin
      v_d = 16'h7fff;
    end else if (s24 < lo) begin
      v_d = lo[15:0];
    end else begin
      v_d = s24[15:0];
    end
    neg = -v_d;
    x_d = v_d[15] ? neg[14:0] : v_d[14:0];
    lz_d = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (x_d[i]) begin
        lz_d = 4'(14 - i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q  <= v_d;
      x_q  <= x_d;
      lz_q <= lz_d;
    end
  end

  // stage B: x/32767 is the 15-bit pattern of x repeated forever, so the
  // tail is never a tie and the guard bit alone decides rounding
  always_comb begin
    wide = {x_q, x_q, x_q, x_q};
    sh   = wide << lz_q;
    expo = 8'd126 - {4'd0, lz_q};
    mag  = {expo, sh[58:36]} + {30'd0, sh[35]};
    case (fmt_i)
      macp_pkg::FMT_U8: begin
        word_d = {24'd0, ~v_q[15], v_q[14:8]};
      end
      macp_pkg::FMT_F32: begin
        if (x_q == 15'd0) begin
          word_d = '0;
        end else if (x_q == 15'h7fff) begin
          word_d = {v_q[15], 8'd127, 23'd0};
        end else begin
          word_d = {v_q[15], mag};
        end
      end
      default: begin
        word_d = {16'd0, v_q};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

>>> sv/macp_out_seq.sv
// ----------------------------------------------------------------------------
// macp_out_seq
// Merging stage: holds one converted frame and issues one ring write per
// output channel, stepping the slot with wrap at the ring size.
// ----------------------------------------------------------------------------
module macp_out_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  macp_pkg::cfg_t              cfg_i,
  input  logic                        valid_i,
  output logic                        load_o,
  input  logic [macp_pkg::SLOT_W-1:0] base_i,
  input  logic [macp_pkg::WORD_W-1:0] word0_i,
  input  logic [macp_pkg::WORD_W-1:0] word1_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [macp_pkg::SLOT_W-1:0] slot_index_o,
  output logic [macp_pkg::WORD_W-1:0] sample_word_o,
  output logic                        last_o
);

  logic                          busy_q;
  logic [macp_pkg::CH_IDX_W-1:0] chan_q;
  logic [macp_pkg::SLOT_W-1:0]   slot_q;
  logic [macp_pkg::WORD_W-1:0]   w0_q, w1_q;
  logic [macp_pkg::CHN_W-1:0]    chan_next;
  logic [macp_pkg::RING_W-1:0]   slot_inc;
  logic                          beat;

  assign chan_next = {1'b0, chan_q} + 1'b1;
  assign slot_inc  = {1'b0, slot_q} + 1'b1;
  assign last_o    = (chan_next == cfg_i.chans);
  assign beat      = busy_q && out_ready_i;
  assign load_o    = !busy_q || (beat && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chan_q <= '0;
    end else if (load_o) begin
      busy_q <= valid_i;
      chan_q <= '0;
    end else if (beat) begin
      chan_q <= chan_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      slot_q <= base_i;
      w0_q   <= word0_i;
      w1_q   <= word1_i;
    end else if (beat) begin
      slot_q <= (slot_inc == cfg_i.ring) ? '0 : slot_inc[macp_pkg::SLOT_W-1:0];
    end
  end

  always_comb begin
    case (chan_q)
      macp_pkg::CH_IDX_W'(0): sample_word_o = w0_q;
      macp_pkg::CH_IDX_W'(1): sample_word_o = w1_q;
      default:                sample_word_o = macp_pkg::zero_word(cfg_i.fmt);
    endcase
  end

  assign out_valid_o  = busy_q;
  assign slot_index_o = slot_q;

endmodule

>>> sv/macp_checker.sv
// ----------------------------------------------------------------------------
// macp_checker
// Port-level checks of the PCM output converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "mix_accumulator_to_pcm_output_macros.svh"

module macp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic pready,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic last_o
);

  // a stalled write stays offered
  `MACP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  // a frame is not cut short before its last channel
  `MACP_ASSERT(a_frame_cont, clk_i, rst_ni, out_valid_o && out_ready_i && !last_o |=> out_valid_o)
  // nothing is offered right after reset
  `MACP_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o)
  // register port never waits
  `MACP_ASSERT(a_pready, clk_i, rst_ni, pready)

endmodule

bind mix_accumulator_to_pcm_output macp_checker u_macp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .last_o      (last_o)
);
